@@ rtl/core/link_receiver_fifo_with_credits_defines.svh @@
// Assertion macros shared by the link receiver RTL.
`ifndef LINK_RECEIVER_FIFO_WITH_CREDITS_DEFINES_SVH
`define LINK_RECEIVER_FIFO_WITH_CREDITS_DEFINES_SVH

`ifndef SYNTHESIS
// Concurrent check sampled on the rising clock edge, off while reset is low.
`define LRF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent check that also holds during reset.
`define LRF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LRF_ASSERT(lbl, clk, rstn, prop, msg)
`define LRF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/core/lrf_pkg.sv @@
`default_nettype none

package lrf_pkg;

  // Default beat width and buffer index width.
  localparam int unsigned BEAT_WIDTH_DEF = 16;
  localparam int unsigned INDEX_BITS_DEF = 4;

  // Read index bit whose toggle returns one credit.
  localparam int unsigned CREDIT_BIT = 3;

  // Width of the word handed to the core.
  localparam int unsigned WORD_WIDTH = 64;

endpackage

`default_nettype wire

@@ rtl/core/lrf_store.sv @@
`default_nettype none

module lrf_store #(
  parameter int unsigned ENTRY_W    = 32,
  parameter int unsigned INDEX_BITS = 4
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [INDEX_BITS-1:0] wr_addr,
  input  wire logic [ENTRY_W-1:0]    wr_data,
  input  wire logic [INDEX_BITS-1:0] rd_addr,
  output logic      [ENTRY_W-1:0]    rd_data
);

  localparam int unsigned Depth = 1 << INDEX_BITS;

  logic [ENTRY_W-1:0] mem [Depth];
  logic [ENTRY_W-1:0] rd_data_r;

  // Entry write, and a prefetch of the entry the next item will read.
  // A write to the prefetched address forwards the new data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/core/link_receiver_fifo_with_credits.sv @@
// The result of an item is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle; the input stalls only while a result waits
// in the output register and the output side is stalled.
// Reset (synchronous, rst_n low) clears pointers, flags, held words and the
// output valid flag; the output data and the entry store are not reset.
`default_nettype none

`include "link_receiver_fifo_with_credits_defines.svh"

module link_receiver_fifo_with_credits #(
  parameter int unsigned BEAT_WIDTH = lrf_pkg::BEAT_WIDTH_DEF,
  parameter int unsigned INDEX_BITS = lrf_pkg::INDEX_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_link_valid,
  input  wire logic [BEAT_WIDTH-1:0]          in_link_beat,
  input  wire logic                           in_sink_ready,
  // Result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [lrf_pkg::WORD_WIDTH-1:0]      out_word_out,
  output logic                                out_word_valid,
  output logic                                out_credit_pulse
);

  import lrf_pkg::*;

  localparam int unsigned EntryW  = 2 * BEAT_WIDTH;
  localparam int unsigned PtrW    = INDEX_BITS + 1;
  localparam int unsigned FullW   = 2 * EntryW;
  localparam int unsigned WideW   = (FullW > WORD_WIDTH) ? FullW : WORD_WIDTH;

  // State
  logic                  half_r,    half_nxt;
  logic [BEAT_WIDTH-1:0] first_r,   first_nxt;
  logic [PtrW-1:0]       wr_idx_r,  wr_idx_nxt;
  logic [PtrW-1:0]       rd_idx_r,  rd_idx_nxt;
  logic [EntryW-1:0]     low_r,     low_nxt;
  logic [WORD_WIDTH-1:0] word_r,    word_nxt;
  logic                  wvld_r,    wvld_nxt;
  logic                  credit_r,  credit_nxt;

  // Output register
  logic                  out_valid_r;
  logic [WORD_WIDTH-1:0] out_word_r;
  logic                  out_wvld_r;
  logic                  out_credit_r;

  logic                  acc;
  logic                  take_first;
  logic                  take_second;
  logic                  nonempty;
  logic                  read_low;
  logic                  read_high;
  logic                  accept_word;
  logic                  toggle;
  logic [PtrW-1:0]       rd_idx_inc;
  logic [EntryW-1:0]     wr_data;
  logic [EntryW-1:0]     rd_data;
  logic [FullW-1:0]      word_full;
  logic [WideW-1:0]      word_wide;

  // An item enters whenever the output register is free or drains this cycle.
  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;

  // Decode of what this item does to the buffer.
  assign take_first  = in_link_valid & ~half_r;
  assign take_second = in_link_valid & half_r;
  assign nonempty    = wr_idx_r != rd_idx_r;
  assign read_low    = nonempty & ~rd_idx_r[0] & ~wvld_r;
  assign read_high   = nonempty & rd_idx_r[0] & ~wvld_r;
  assign accept_word = in_sink_ready & wvld_r;
  assign rd_idx_inc  = rd_idx_r + PtrW'(1);
  assign toggle      = rd_idx_inc[CREDIT_BIT] ^ rd_idx_r[CREDIT_BIT];

  // Second beat goes in the upper half of the entry.
  assign wr_data   = {in_link_beat, first_r};
  assign word_full = {rd_data, low_r};
  assign word_wide = WideW'(word_full);

  // Next state for one accepted item.
  always_comb begin
    half_nxt   = half_r;
    first_nxt  = first_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    low_nxt    = low_r;
    word_nxt   = word_r;
    wvld_nxt   = wvld_r;
    credit_nxt = credit_r;
    if (acc) begin
      if (take_first) begin
        half_nxt  = 1'b1;
        first_nxt = in_link_beat;
      end
      if (take_second) begin
        half_nxt   = 1'b0;
        wr_idx_nxt = wr_idx_r + PtrW'(1);
      end
      if (read_low) begin
        low_nxt    = rd_data;
        rd_idx_nxt = rd_idx_inc;
      end
      credit_nxt = read_high & toggle;
      if (read_high) begin
        word_nxt   = word_wide[WORD_WIDTH-1:0];
        wvld_nxt   = 1'b1;
        rd_idx_nxt = rd_idx_inc;
      end else if (accept_word) begin
        wvld_nxt = 1'b0;
      end
    end
  end

  // Entry store with registered read of the entry at the next read index.
  lrf_store #(
    .ENTRY_W    (EntryW),
    .INDEX_BITS (INDEX_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (acc & take_second),
    .wr_addr (wr_idx_r[INDEX_BITS-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_idx_nxt[INDEX_BITS-1:0]),
    .rd_data (rd_data)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r   <= 1'b0;
      first_r  <= '0;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      low_r    <= '0;
      word_r   <= '0;
      wvld_r   <= 1'b0;
      credit_r <= 1'b0;
    end else begin
      half_r   <= half_nxt;
      first_r  <= first_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      low_r    <= low_nxt;
      word_r   <= word_nxt;
      wvld_r   <= wvld_nxt;
      credit_r <= credit_nxt;
    end
  end

  // Output register: loaded with the state after each item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_word_r   <= word_nxt;
      out_wvld_r   <= wvld_nxt;
      out_credit_r <= credit_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_word_out     = out_word_r;
  assign out_word_valid   = out_wvld_r;
  assign out_credit_pulse = out_credit_r;

  // An accepted item always produces a result in the next cycle.
  `LRF_ASSERT(a_item_result, clk, rst_n, acc |=> out_valid_r, "accepted item gave no result")
  // A credit is only returned together with a freshly completed word.
  `LRF_ASSERT(a_credit_word, clk, rst_n, credit_r |-> wvld_r, "credit without a word")
  // A credit leaves the read index on an eight-entry boundary.
  `LRF_ASSERT_ALWAYS(a_credit_align, clk,
    credit_r |-> (rd_idx_r[CREDIT_BIT-1:0] == '0), "credit off an eight-entry boundary")
  // The read index only moves while no word is held.
  `LRF_ASSERT(a_read_hold, clk, rst_n,
    (acc && wvld_r) |=> (rd_idx_r == $past(rd_idx_r)), "read while a word is pending")

endmodule

`default_nettype wire
